>>> hdl/assert_macros.svh
// assertion helpers shared by vfc_front and vfc_back
// every use expects i_clk and i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define VFC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vfc assertion failed");

// next-cycle implication
`define VFC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vfc assertion failed");

`endif

>>> hdl/vfc_pkg.sv
// ----------------------------------------------------------------------------
// vfc_pkg
// Types, codes and constants of the voxel face visibility culler.
// ----------------------------------------------------------------------------
`default_nettype none

package vfc_pkg;

    localparam int POS_W    = 5;
    localparam int KIND_W   = 3;
    localparam int MASK_W   = 6;
    localparam int POS_SPAN = 1 << POS_W;

    localparam int GRID_X_DEF = 32;
    localparam int GRID_Y_DEF = 32;
    localparam int GRID_Z_DEF = 32;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // face bit positions in the mask
    localparam int FACE_PZ = 0;
    localparam int FACE_MZ = 1;
    localparam int FACE_MX = 2;
    localparam int FACE_PX = 3;
    localparam int FACE_PY = 4;
    localparam int FACE_MY = 5;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_RD1,
        BS_FIN
    } t_back_state;

    typedef struct packed {
        t_op               op;
        logic              in_grid;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [POS_W-1:0]  pos_z;
        logic [KIND_W-1:0] new_kind;
    } t_cmd;

    typedef struct packed {
        logic clearing;
    } t_back_status;

    // coordinates are only POS_W bits wide, so a larger grid is never reached
    function automatic int eff_dim(input int grid);
        return (grid < POS_SPAN) ? grid : POS_SPAN;
    endfunction

endpackage

`default_nettype wire

>>> hdl/vfc_channels.sv
// ----------------------------------------------------------------------------
// vfc channels
// Valid/ready channels for the item input and the result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface vfc_in_if;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [vfc_pkg::POS_W-1:0]  pos_x;
    logic [vfc_pkg::POS_W-1:0]  pos_y;
    logic [vfc_pkg::POS_W-1:0]  pos_z;
    logic [vfc_pkg::KIND_W-1:0] new_kind;

    modport source (output valid, op, pos_x, pos_y, pos_z, new_kind, input ready);
    modport sink   (input valid, op, pos_x, pos_y, pos_z, new_kind, output ready);
endinterface

interface vfc_out_if;
    logic                       valid;
    logic                       ready;
    logic [vfc_pkg::KIND_W-1:0] block_kind;
    logic [vfc_pkg::MASK_W-1:0] face_mask;

    modport source (output valid, block_kind, face_mask, input ready);
    modport sink   (input valid, block_kind, face_mask, output ready);
endinterface

`default_nettype wire

>>> hdl/vfc_ram.sv
// ----------------------------------------------------------------------------
// vfc_ram
// Grid store copy: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module vfc_ram #(
    parameter int DEPTH = vfc_pkg::GRID_X_DEF * vfc_pkg::GRID_Y_DEF * vfc_pkg::GRID_Z_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [AW-1:0]              i_waddr,
    input  wire logic [vfc_pkg::KIND_W-1:0] i_wdata,
    input  wire logic                       i_re,
    input  wire logic [AW-1:0]              i_raddr_a,
    input  wire logic [AW-1:0]              i_raddr_b,
    output logic      [vfc_pkg::KIND_W-1:0] o_rdata_a,
    output logic      [vfc_pkg::KIND_W-1:0] o_rdata_b
);

    logic [vfc_pkg::KIND_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

>>> hdl/vfc_front.sv
// ----------------------------------------------------------------------------
// vfc_front
// Accepts items, flags coordinates outside the grid, queues commands.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module vfc_front #(
    parameter int GRID_X = vfc_pkg::GRID_X_DEF,
    parameter int GRID_Y = vfc_pkg::GRID_Y_DEF,
    parameter int GRID_Z = vfc_pkg::GRID_Z_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    vfc_in_if.sink                     i_in,
    input  wire vfc_pkg::t_back_status i_status,
    output vfc_pkg::t_cmd              o_cmd,
    output logic                       o_cmd_valid,
    input  wire logic                  i_cmd_pop
);

    localparam int DX = vfc_pkg::eff_dim(GRID_X);
    localparam int DY = vfc_pkg::eff_dim(GRID_Y);
    localparam int DZ = vfc_pkg::eff_dim(GRID_Z);

    vfc_pkg::t_cmd                    r_q [vfc_pkg::QUEUE_DEPTH];
    logic [vfc_pkg::QPTR_W-1:0]       r_wr_ptr, n_wr_ptr;
    logic [vfc_pkg::QPTR_W-1:0]       r_rd_ptr, n_rd_ptr;
    logic [vfc_pkg::QCNT_W-1:0]       r_count, n_count;
    logic                             push;
    vfc_pkg::t_cmd                    cmd_in;

    assign i_in.ready = (r_count != vfc_pkg::QCNT_W'(vfc_pkg::QUEUE_DEPTH))
                        && !i_status.clearing;
    assign push = i_in.valid && i_in.ready;

    always_comb begin
        cmd_in.op       = vfc_pkg::t_op'(i_in.op);
        cmd_in.in_grid  = (int'(i_in.pos_x) < DX) && (int'(i_in.pos_y) < DY)
                          && (int'(i_in.pos_z) < DZ);
        cmd_in.pos_x    = i_in.pos_x;
        cmd_in.pos_y    = i_in.pos_y;
        cmd_in.pos_z    = i_in.pos_z;
        cmd_in.new_kind = i_in.new_kind;
    end

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_cmd_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !i_cmd_pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_cmd_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

    assign o_cmd       = r_q[r_rd_ptr];
    assign o_cmd_valid = (r_count != '0);

    `VFC_ASSERT_IMP(a_pop_nonempty, i_cmd_pop, r_count != '0)

endmodule

`default_nettype wire

>>> hdl/vfc_back.sv
// ----------------------------------------------------------------------------
// vfc_back
// Clears the grid after reset, executes writes and queries against two
// copies of the grid store, and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module vfc_back #(
    parameter int GRID_X = vfc_pkg::GRID_X_DEF,
    parameter int GRID_Y = vfc_pkg::GRID_Y_DEF,
    parameter int GRID_Z = vfc_pkg::GRID_Z_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire vfc_pkg::t_cmd i_cmd,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_pop,
    output vfc_pkg::t_back_status o_status,
    vfc_out_if.source          o_out
);

    localparam int DX     = vfc_pkg::eff_dim(GRID_X);
    localparam int DY     = vfc_pkg::eff_dim(GRID_Y);
    localparam int DZ     = vfc_pkg::eff_dim(GRID_Z);
    localparam int DEPTH  = DX * DY * DZ;
    localparam int AW     = $clog2(DEPTH);
    localparam int STEP_X = DY * DZ;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    localparam int KW = vfc_pkg::KIND_W;
    localparam int MW = vfc_pkg::MASK_W;

    vfc_pkg::t_back_state r_state, n_state;
    logic [AW-1:0]        r_clr_addr, n_clr_addr;
    logic                 r_out_valid, n_out_valid;
    logic [KW-1:0]        r_out_kind, n_out_kind;
    logic [MW-1:0]        r_out_mask, n_out_mask;

    // query context, payload only
    logic [AW-1:0]        r_center;
    logic [MW-1:0]        r_nv;
    logic [KW-1:0]        r_kind_c, r_kind_pz, r_kind_mz, r_kind_mx;

    logic                 out_free;
    logic                 is_query;
    logic                 start_query;
    logic                 simple_done;
    logic                 query_done;
    logic                 out_load;
    logic [AW-1:0]        cmd_center;
    logic [MW-1:0]        cmd_nv;
    logic [MW-1:0]        query_mask;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [KW-1:0]        ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram0_addr_a, ram0_addr_b, ram1_addr_a, ram1_addr_b;
    logic [KW-1:0]        ram0_data_a, ram0_data_b, ram1_data_a, ram1_data_b;

    assign out_free = !r_out_valid || o_out.ready;
    assign is_query = (i_cmd.op == vfc_pkg::OP_QUERY) && i_cmd.in_grid;

    // linear address and neighbor presence of the queued command
    always_comb begin
        cmd_center = AW'((int'(i_cmd.pos_x) * DY + int'(i_cmd.pos_y)) * DZ
                         + int'(i_cmd.pos_z));
        cmd_nv                   = '0;
        cmd_nv[vfc_pkg::FACE_PZ] = (int'(i_cmd.pos_z) + 1) < DZ;
        cmd_nv[vfc_pkg::FACE_MZ] = i_cmd.pos_z != '0;
        cmd_nv[vfc_pkg::FACE_MX] = i_cmd.pos_x != '0;
        cmd_nv[vfc_pkg::FACE_PX] = (int'(i_cmd.pos_x) + 1) < DX;
        cmd_nv[vfc_pkg::FACE_PY] = (int'(i_cmd.pos_y) + 1) < DY;
        cmd_nv[vfc_pkg::FACE_MY] = i_cmd.pos_y != '0;
    end

    // face visible when the neighbor is absent or air; no face when the block is air
    always_comb begin
        query_mask                   = '0;
        query_mask[vfc_pkg::FACE_PZ] = !r_nv[vfc_pkg::FACE_PZ] || (r_kind_pz == '0);
        query_mask[vfc_pkg::FACE_MZ] = !r_nv[vfc_pkg::FACE_MZ] || (r_kind_mz == '0);
        query_mask[vfc_pkg::FACE_MX] = !r_nv[vfc_pkg::FACE_MX] || (r_kind_mx == '0);
        query_mask[vfc_pkg::FACE_PX] = !r_nv[vfc_pkg::FACE_PX] || (ram0_data_a == '0);
        query_mask[vfc_pkg::FACE_PY] = !r_nv[vfc_pkg::FACE_PY] || (ram0_data_b == '0);
        query_mask[vfc_pkg::FACE_MY] = !r_nv[vfc_pkg::FACE_MY] || (ram1_data_a == '0);
        if (r_kind_c == '0) begin
            query_mask = '0;
        end
    end

    // control outputs of the sequencer
    always_comb begin
        o_cmd_pop   = 1'b0;
        start_query = 1'b0;
        simple_done = 1'b0;
        query_done  = 1'b0;
        case (r_state)
            vfc_pkg::BS_IDLE: begin
                o_cmd_pop   = i_cmd_valid && (is_query || out_free);
                start_query = o_cmd_pop && is_query;
                simple_done = o_cmd_pop && !is_query;
            end
            vfc_pkg::BS_FIN: begin
                query_done  = out_free;
                // the result slot is taken, so only a query may follow at once
                o_cmd_pop   = out_free && i_cmd_valid && is_query;
                start_query = o_cmd_pop;
            end
            default: begin
                o_cmd_pop = 1'b0;
            end
        endcase
        out_load = simple_done || query_done;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            vfc_pkg::BS_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = vfc_pkg::BS_IDLE;
                end
            end
            vfc_pkg::BS_IDLE: begin
                if (start_query) begin
                    n_state = vfc_pkg::BS_RD1;
                end
            end
            vfc_pkg::BS_RD1: begin
                n_state = vfc_pkg::BS_FIN;
            end
            vfc_pkg::BS_FIN: begin
                if (query_done) begin
                    n_state = start_query ? vfc_pkg::BS_RD1 : vfc_pkg::BS_IDLE;
                end
            end
            default: begin
                n_state = vfc_pkg::BS_IDLE;
            end
        endcase
    end

    // store ports: first read group in the pop cycle, second group in rd1
    always_comb begin
        ram_we    = (r_state == vfc_pkg::BS_CLEAR)
                    || (simple_done && i_cmd.in_grid && (i_cmd.op == vfc_pkg::OP_WRITE));
        ram_waddr = (r_state == vfc_pkg::BS_CLEAR) ? r_clr_addr : cmd_center;
        ram_wdata = (r_state == vfc_pkg::BS_CLEAR) ? '0 : i_cmd.new_kind;
        ram_re    = start_query || (r_state == vfc_pkg::BS_RD1);
        if (r_state == vfc_pkg::BS_RD1) begin
            ram0_addr_a = r_nv[vfc_pkg::FACE_PX] ? r_center + AW'(STEP_X) : r_center;
            ram0_addr_b = r_nv[vfc_pkg::FACE_PY] ? r_center + AW'(DZ) : r_center;
            ram1_addr_a = r_nv[vfc_pkg::FACE_MY] ? r_center - AW'(DZ) : r_center;
            ram1_addr_b = r_center;
        end else begin
            ram0_addr_a = cmd_center;
            ram0_addr_b = cmd_nv[vfc_pkg::FACE_PZ] ? cmd_center + AW'(1) : cmd_center;
            ram1_addr_a = cmd_nv[vfc_pkg::FACE_MZ] ? cmd_center - AW'(1) : cmd_center;
            ram1_addr_b = cmd_nv[vfc_pkg::FACE_MX] ? cmd_center - AW'(STEP_X) : cmd_center;
        end
    end

    always_comb begin
        n_clr_addr  = (r_state == vfc_pkg::BS_CLEAR) ? r_clr_addr + AW'(1) : r_clr_addr;
        n_out_valid = out_load ? 1'b1 : (o_out.ready ? 1'b0 : r_out_valid);
        n_out_kind  = r_out_kind;
        n_out_mask  = r_out_mask;
        if (simple_done) begin
            n_out_kind = i_cmd.in_grid ? i_cmd.new_kind : '0;
            n_out_mask = '0;
        end else if (query_done) begin
            n_out_kind = r_kind_c;
            n_out_mask = query_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vfc_pkg::BS_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind <= n_out_kind;
        r_out_mask <= n_out_mask;
        if (start_query) begin
            r_center <= cmd_center;
            r_nv     <= cmd_nv;
        end
        if (r_state == vfc_pkg::BS_RD1) begin
            r_kind_c  <= ram0_data_a;
            r_kind_pz <= ram0_data_b;
            r_kind_mz <= ram1_data_a;
            r_kind_mx <= ram1_data_b;
        end
    end

    vfc_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram0 (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_re      (ram_re),
        .i_raddr_a (ram0_addr_a),
        .i_raddr_b (ram0_addr_b),
        .o_rdata_a (ram0_data_a),
        .o_rdata_b (ram0_data_b)
    );

    vfc_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram1 (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_re      (ram_re),
        .i_raddr_a (ram1_addr_a),
        .i_raddr_b (ram1_addr_b),
        .o_rdata_a (ram1_data_a),
        .o_rdata_b (ram1_data_b)
    );

    assign o_status.clearing = (r_state == vfc_pkg::BS_CLEAR);

    assign o_out.valid      = r_out_valid;
    assign o_out.block_kind = r_out_kind;
    assign o_out.face_mask  = r_out_mask;

    `VFC_ASSERT_IMP(a_no_result_in_clear, r_state == vfc_pkg::BS_CLEAR, !out_load)
    `VFC_ASSERT_IMP(a_no_rw_overlap, ram_we, !ram_re)
    `VFC_ASSERT_IMP(a_pop_has_cmd, o_cmd_pop, i_cmd_valid)
    `VFC_ASSERT_NXT(a_query_enters_rd1, start_query, r_state == vfc_pkg::BS_RD1)

endmodule

`default_nettype wire

>>> hdl/voxel_face_visibility_culler_unit.sv
// ----------------------------------------------------------------------------
// voxel_face_visibility_culler_unit
// Block-type grid with write and face-visibility query items.
//
//   channel   dir   beat payload
//   i_in      in    op, pos_x, pos_y, pos_z, new_kind
//   o_out     out   block_kind, face_mask
//
// after reset a clearing pass writes air to every cell, one per cycle, with
// i_in.ready low until it is done
// a write or an out-of-grid item is loaded into the output register at its pop
// a query makes seven grid reads over two store copies with two read ports each,
// first group at the pop, second in rd1; the result is loaded in fin
// a two-beat command queue and the output register let each side stall alone
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_face_visibility_culler_unit #(
    parameter int GRID_X = vfc_pkg::GRID_X_DEF,
    parameter int GRID_Y = vfc_pkg::GRID_Y_DEF,
    parameter int GRID_Z = vfc_pkg::GRID_Z_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    vfc_in_if.sink    i_in,
    vfc_out_if.source o_out
);

    vfc_pkg::t_cmd        cmd;
    logic                 cmd_valid;
    logic                 cmd_pop;
    vfc_pkg::t_back_status status;

    vfc_front #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y),
        .GRID_Z (GRID_Z)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    vfc_back #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y),
        .GRID_Z (GRID_Z)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_status    (status),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

>>> tb/voxel_face_visibility_culler_unit_tb.sv
// ----------------------------------------------------------------------------
// voxel_face_visibility_culler_unit_tb
// Drives block writes and face queries into the culler. Each beat is run
// through a local copy of the voxel grid to get the expected block kind and
// visible-face mask. Every returned beat is checked against the oldest
// expectation. Both channels stall at random; the clearing pass after reset
// is waited out through the handshake.
// ----------------------------------------------------------------------------
module voxel_face_visibility_culler_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GX          = vfc_pkg::GRID_X_DEF;
    localparam int GY          = vfc_pkg::GRID_Y_DEF;
    localparam int GZ          = vfc_pkg::GRID_Z_DEF;
    localparam int PW          = vfc_pkg::POS_W;
    localparam int KW          = vfc_pkg::KIND_W;
    localparam int MW          = vfc_pkg::MASK_W;
    localparam int CELLS       = GX * GY * GZ;
    localparam int RAND_CMDS   = 1200;
    localparam int DRAIN_WAIT  = 20;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        vfc_pkg::t_op  op;
        logic [PW-1:0] x;
        logic [PW-1:0] y;
        logic [PW-1:0] z;
        logic [KW-1:0] kind;
    } t_voxel_cmd;

    typedef struct packed {
        logic [KW-1:0] kind;
        logic [MW-1:0] mask;
    } t_cell_view;

    logic i_clk;
    logic i_rst_n;

    vfc_in_if  in_ch ();
    vfc_out_if out_ch ();

    voxel_face_visibility_culler_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // local copy of the grid, air after reset
    logic [KW-1:0] grid_kinds [0:CELLS-1];

    t_voxel_cmd voxel_cmds_q [$];
    t_cell_view cell_views_q [$];

    int  cmds_total;
    int  cmds_taken;
    int  mismatches;
    int  cycles;
    int  send_gap;
    int  hold_left;
    bit  in_took;
    bit  calm;

    t_voxel_cmd next_cmd;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic logic [KW-1:0] kind_at(input int x, input int y, input int z);
        if (x < 0 || x >= GX || y < 0 || y >= GY || z < 0 || z >= GZ)
            return '0;
        return grid_kinds[(x * GY + y) * GZ + z];
    endfunction

    // updates the grid copy and returns what the block should report
    function automatic t_cell_view apply_voxel_cmd(input t_voxel_cmd c);
        t_cell_view v;
        int x;
        int y;
        int z;
        x = c.x;
        y = c.y;
        z = c.z;
        v = '0;
        if (x >= GX || y >= GY || z >= GZ)
            return v;
        if (c.op == vfc_pkg::OP_WRITE) begin
            grid_kinds[(x * GY + y) * GZ + z] = c.kind;
            v.kind = c.kind;
            return v;
        end
        v.kind = kind_at(x, y, z);
        if (v.kind != '0) begin
            v.mask[vfc_pkg::FACE_PZ] = (kind_at(x, y, z + 1) == '0);
            v.mask[vfc_pkg::FACE_MZ] = (kind_at(x, y, z - 1) == '0);
            v.mask[vfc_pkg::FACE_MX] = (kind_at(x - 1, y, z) == '0);
            v.mask[vfc_pkg::FACE_PX] = (kind_at(x + 1, y, z) == '0);
            v.mask[vfc_pkg::FACE_PY] = (kind_at(x, y + 1, z) == '0);
            v.mask[vfc_pkg::FACE_MY] = (kind_at(x, y - 1, z) == '0);
        end
        return v;
    endfunction

    function automatic int draw_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [KW-1:0] draw_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return '0;
        if (r < 22)
            return KW'(7);
        return KW'($urandom_range(1, 6));
    endfunction

    task automatic add_cmd(input vfc_pkg::t_op op, input int x, input int y, input int z,
                           input int kind);
        t_voxel_cmd c;
        c.op   = op;
        c.x    = PW'(x);
        c.y    = PW'(y);
        c.z    = PW'(z);
        c.kind = KW'(kind);
        voxel_cmds_q = {voxel_cmds_q, c};
    endtask

    // input side: one beat from the queue, then a random gap
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_took) begin
            in_took = 1'b0;
            if (send_gap > 0 || voxel_cmds_q.size() == 0) begin
                if (send_gap > 0)
                    send_gap--;
                in_ch.valid <= 1'b0;
            end else begin
                next_cmd = voxel_cmds_q.pop_front();
                in_ch.valid    <= 1'b1;
                in_ch.op       <= next_cmd.op;
                in_ch.pos_x    <= next_cmd.x;
                in_ch.pos_y    <= next_cmd.y;
                in_ch.pos_z    <= next_cmd.z;
                in_ch.new_kind <= next_cmd.kind;
                send_gap = draw_gap();
            end
        end
    end

    // output side: random stalls on ready
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                hold_left = draw_gap();
        end
    end

    // accepted beats on both channels, plus the cycle limit
    always @(posedge i_clk) begin
        t_cell_view want;
        t_cell_view fresh;
        cycles++;
        if (cycles % 256 == 0)
            calm = ($urandom_range(0, 3) == 0);
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end else if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                in_took = 1'b1;
                cmds_taken++;
                fresh = apply_voxel_cmd({vfc_pkg::t_op'(in_ch.op), in_ch.pos_x,
                    in_ch.pos_y, in_ch.pos_z, in_ch.new_kind});
                cell_views_q = {cell_views_q, fresh};
            end
            if (out_ch.valid && out_ch.ready) begin
                if (cell_views_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: kind %0d mask %b",
                                 out_ch.block_kind, out_ch.face_mask);
                end else begin
                    want = cell_views_q.pop_front();
                    if (out_ch.block_kind !== want.kind || out_ch.face_mask !== want.mask) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: kind exp %0d got %0d, mask exp %b got %b",
                                     want.kind, out_ch.block_kind, want.mask,
                                     out_ch.face_mask);
                    end
                end
            end
        end
    end

    initial begin
        int bx;
        int by;
        int bz;
        int x;
        int y;
        int z;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.op       = vfc_pkg::OP_WRITE;
        in_ch.pos_x    = '0;
        in_ch.pos_y    = '0;
        in_ch.pos_z    = '0;
        in_ch.new_kind = '0;
        out_ch.ready   = 1'b0;
        in_took        = 1'b0;
        calm           = 1'b0;
        send_gap       = 0;
        hold_left      = 0;
        cycles         = 0;
        cmds_taken     = 0;
        mismatches     = 0;
        foreach (grid_kinds[i])
            grid_kinds[i] = '0;

        // corners, kind 7, a fully enclosed block, then one face opened
        add_cmd(vfc_pkg::OP_QUERY, 0, 0, 0, 5);
        add_cmd(vfc_pkg::OP_WRITE, 0, 0, 0, 1);
        add_cmd(vfc_pkg::OP_QUERY, 0, 0, 0, 0);
        add_cmd(vfc_pkg::OP_WRITE, 31, 31, 31, 7);
        add_cmd(vfc_pkg::OP_QUERY, 31, 31, 31, 7);
        add_cmd(vfc_pkg::OP_WRITE, 10, 10, 10, 3);
        add_cmd(vfc_pkg::OP_WRITE, 10, 10, 11, 1);
        add_cmd(vfc_pkg::OP_WRITE, 10, 10, 9, 2);
        add_cmd(vfc_pkg::OP_WRITE, 9, 10, 10, 3);
        add_cmd(vfc_pkg::OP_WRITE, 11, 10, 10, 4);
        add_cmd(vfc_pkg::OP_WRITE, 10, 11, 10, 5);
        add_cmd(vfc_pkg::OP_WRITE, 10, 9, 10, 6);
        add_cmd(vfc_pkg::OP_QUERY, 10, 10, 10, 0);
        add_cmd(vfc_pkg::OP_WRITE, 10, 10, 11, 0);
        add_cmd(vfc_pkg::OP_QUERY, 10, 10, 10, 0);
        add_cmd(vfc_pkg::OP_QUERY, 10, 10, 11, 0);
        add_cmd(vfc_pkg::OP_WRITE, 0, 0, 1, 2);
        add_cmd(vfc_pkg::OP_QUERY, 0, 0, 0, 0);
        add_cmd(vfc_pkg::OP_WRITE, 31, 0, 31, 4);
        add_cmd(vfc_pkg::OP_QUERY, 31, 0, 31, 0);
        add_cmd(vfc_pkg::OP_WRITE, 0, 31, 0, 6);
        add_cmd(vfc_pkg::OP_QUERY, 0, 31, 0, 0);

        // mostly small neighborhoods so queries see mixed neighbors
        bx = 0;
        by = 0;
        bz = 0;
        for (int n = 0; n < RAND_CMDS; n++) begin
            if (n % 40 == 0) begin
                bx = ($urandom_range(0, 3) == 0) ? 28 * $urandom_range(0, 1) : $urandom_range(0, 28);
                by = ($urandom_range(0, 3) == 0) ? 28 * $urandom_range(0, 1) : $urandom_range(0, 28);
                bz = ($urandom_range(0, 3) == 0) ? 28 * $urandom_range(0, 1) : $urandom_range(0, 28);
            end
            if ($urandom_range(0, 9) == 0) begin
                x = $urandom_range(0, 31);
                y = $urandom_range(0, 31);
                z = $urandom_range(0, 31);
            end else begin
                x = bx + $urandom_range(0, 3);
                y = by + $urandom_range(0, 3);
                z = bz + $urandom_range(0, 3);
            end
            if ($urandom_range(0, 99) < 55)
                add_cmd(vfc_pkg::OP_WRITE, x, y, z, int'(draw_kind()));
            else
                add_cmd(vfc_pkg::OP_QUERY, x, y, z, $urandom_range(0, 7));
        end
        cmds_total = voxel_cmds_q.size();

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!(cmds_taken == cmds_total && cell_views_q.size() == 0))
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
